// ----- hdl/bmvg_pkg.sv -----
// ----------------------------------------------------------------------------
// Box mesh vertex generator package
// Shared types, widths, codes and helper functions for the vertex pipeline.
// ----------------------------------------------------------------------------
package bmvg_pkg;

    localparam int SEG_W        = 7;
    localparam int EXT_W        = 16;
    localparam int NB_W         = 13;
    localparam int IDX_W        = 15;
    localparam int TEX_W        = 17;
    localparam int MAX_SEGMENTS = 64;

    localparam int DIVIDEND_W = 23;
    localparam int DIVISOR_W  = 8;
    localparam int QUO_W      = 17;
    localparam int REM_W      = DIVISOR_W;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    localparam int NUM_STAGES = DIV_STAGES + 3;
    localparam int ST_A       = 0;
    localparam int ST_B       = 1;
    localparam int ST_DIV0    = 2;
    localparam int ST_OUT     = NUM_STAGES - 1;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_BOX_WIDTH  = 3'd0;
    localparam logic [2:0] REG_BOX_HEIGHT = 3'd1;
    localparam logic [2:0] REG_BOX_DEPTH  = 3'd2;
    localparam logic [2:0] REG_SEGMENTS_X = 3'd3;
    localparam logic [2:0] REG_SEGMENTS_Y = 3'd4;
    localparam logic [2:0] REG_SEGMENTS_Z = 3'd5;

    localparam logic [EXT_W-1:0] EXT_RESET = 16'd256;
    localparam logic [SEG_W-1:0] SEG_RESET = 7'd1;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    typedef struct packed {
        logic [2:0]       face;
        logic [SEG_W-1:0] column;
        logic [SEG_W-1:0] row;
    } req_t;

    typedef struct packed {
        logic                    in_grid;
        logic signed [EXT_W-1:0] pos_x;
        logic signed [EXT_W-1:0] pos_y;
        logic signed [EXT_W-1:0] pos_z;
        logic [1:0]              normal_axis;
        logic                    normal_negative;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic [IDX_W-1:0]        vertex_index;
        logic                    quad_valid;
        logic                    top_edge_line;
        logic                    right_edge_line;
    } vtx_t;

    typedef struct packed {
        logic [EXT_W-1:0] box_width;
        logic [EXT_W-1:0] box_height;
        logic [EXT_W-1:0] box_depth;
        logic [SEG_W-1:0] segments_x;
        logic [SEG_W-1:0] segments_y;
        logic [SEG_W-1:0] segments_z;
    } cfg_t;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_op_t;

    typedef struct packed {
        logic             in_grid;
        logic [2:0]       face;
        logic             u_neg;
        logic             v_neg;
        logic [EXT_W-1:0] off;
        logic             normal_neg;
        logic [IDX_W-1:0] index;
        logic             quad;
        logic             top;
        logic             right;
    } side_t;

    function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] s);
        logic [SEG_W-1:0] r;
        if (s == '0)
            r = SEG_W'(1);
        else if (s > SEG_W'(MAX_SEGMENTS))
            r = SEG_W'(MAX_SEGMENTS);
        else
            r = s;
        return r;
    endfunction

    function automatic logic signed [EXT_W-1:0] sat_coord(input logic [QUO_W-1:0] q,
                                                          input logic neg);
        logic [QUO_W-1:0]        nq;
        logic signed [EXT_W-1:0] r;
        nq = ~q + QUO_W'(1);
        if (neg)
            r = nq[EXT_W-1:0];
        else if (q > QUO_W'(32767))
            r = 16'sh7fff;
        else
            r = q[EXT_W-1:0];
        return r;
    endfunction

endpackage

// ----- hdl/bmvg_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, a few quotient bits per register stage.
// ----------------------------------------------------------------------------
module bmvg_div (
    input  logic                            clk,
    input  logic [bmvg_pkg::DIV_STAGES-1:0] en,
    input  bmvg_pkg::div_op_t               op,
    output logic [bmvg_pkg::QUO_W-1:0]      quotient
);
    import bmvg_pkg::*;

    logic [REM_W-1:0] rem_reg  [DIV_STAGES];
    logic [REM_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];
    div_op_t          op_reg   [DIV_STAGES];
    logic [REM_W-1:0] rem_in   [DIV_STAGES];
    logic [QUO_W-1:0] quo_in   [DIV_STAGES];
    div_op_t          op_in    [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [REM_W-1:0] r_chain [DIV_STEPS+1];
        logic [QUO_W-1:0] q_chain [DIV_STEPS+1];

        if (s == 0) begin : g_first
            assign rem_in[s] = REM_W'(op.dividend[DIVIDEND_W-1:QUO_W]);
            assign quo_in[s] = '0;
            assign op_in[s]  = op;
        end
        else begin : g_next
            assign rem_in[s] = rem_reg[s-1];
            assign quo_in[s] = quo_reg[s-1];
            assign op_in[s]  = op_reg[s-1];
        end

        assign r_chain[0] = rem_in[s];
        assign q_chain[0] = quo_in[s];

        for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
            localparam int P = QUO_W - 1 - (s * DIV_STEPS + j);
            if (P >= 0) begin : g_bit
                logic [REM_W-1:0] shifted;
                logic             ge;
                assign shifted = {r_chain[j][REM_W-2:0], op_in[s].dividend[P]};
                assign ge      = (shifted >= op_in[s].divisor);
                assign r_chain[j+1] = ge ? (shifted - op_in[s].divisor) : shifted;
                assign q_chain[j+1] = {q_chain[j][QUO_W-2:0], ge};
            end
            else begin : g_pass
                assign r_chain[j+1] = r_chain[j];
                assign q_chain[j+1] = q_chain[j];
            end
        end

        assign rem_next[s] = r_chain[DIV_STEPS];
        assign quo_next[s] = q_chain[DIV_STEPS];

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                op_reg[s]  <= op_in[s];
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

// ----- hdl/bmvg_setup.sv -----
// ----------------------------------------------------------------------------
// Vertex setup stages
// Face selection and grid offsets, then products, index and divider operands.
// ----------------------------------------------------------------------------
module bmvg_setup (
    input  logic                clk,
    input  logic                en_a,
    input  logic                en_b,
    input  bmvg_pkg::req_t      req,
    input  bmvg_pkg::cfg_t      cfg,
    output bmvg_pkg::side_t     side,
    output bmvg_pkg::div_op_t   pos_u_op,
    output bmvg_pkg::div_op_t   pos_v_op,
    output bmvg_pkg::div_op_t   tex_u_op,
    output bmvg_pkg::div_op_t   tex_v_op
);
    import bmvg_pkg::*;

    logic [SEG_W-1:0] sx, sy, sz, gc, gr;
    logic [EXT_W-1:0] eu, ev, en;
    logic [SEG_W:0]   col2, row2, gc8, gr8, mu8, mv8, sx1, sy1, sz1;
    logic             mu_neg, mv_neg, in_grid;
    logic [15:0]      nx_full, ny_full, nz_full;

    logic [2:0]       a_face_reg;
    logic [SEG_W-1:0] a_col_reg, a_row_reg, a_gc_reg, a_gr_reg, a_mu_reg, a_mv_reg;
    logic [EXT_W-1:0] a_eu_reg, a_ev_reg, a_en_reg;
    logic             a_mu_neg_reg, a_mv_neg_reg, a_in_grid_reg;
    logic [NB_W-1:0]  a_nx_reg, a_ny_reg, a_nz_reg;

    logic [DIVIDEND_W-1:0] prod_u, prod_v;
    logic [IDX_W-1:0]      base, nx2, row_step, index;
    logic [SEG_W:0]        gc1;
    logic [EXT_W:0]        en_inc;

    side_t   side_next, side_reg;
    div_op_t pos_u_next, pos_v_next, tex_u_next, tex_v_next;
    div_op_t pos_u_reg, pos_v_reg, tex_u_reg, tex_v_reg;

    always_comb
    begin
        sx = clamp_seg(cfg.segments_x);
        sy = clamp_seg(cfg.segments_y);
        sz = clamp_seg(cfg.segments_z);
        case (req.face) inside
            FACE_PX, FACE_NX:
            begin
                gc = sz; gr = sy;
                eu = cfg.box_depth; ev = cfg.box_height; en = cfg.box_width;
            end
            FACE_PY, FACE_NY:
            begin
                gc = sx; gr = sz;
                eu = cfg.box_width; ev = cfg.box_depth; en = cfg.box_height;
            end
            default:
            begin
                gc = sx; gr = sy;
                eu = cfg.box_width; ev = cfg.box_height; en = cfg.box_depth;
            end
        endcase
        col2    = {req.column, 1'b0};
        row2    = {req.row, 1'b0};
        gc8     = {1'b0, gc};
        gr8     = {1'b0, gr};
        mu_neg  = (col2 < gc8);
        mv_neg  = (row2 < gr8);
        mu8     = mu_neg ? (gc8 - col2) : (col2 - gc8);
        mv8     = mv_neg ? (gr8 - row2) : (row2 - gr8);
        in_grid = (req.face <= FACE_NZ) && (req.column <= gc) && (req.row <= gr);
        sx1     = {1'b0, sx} + (SEG_W+1)'(1);
        sy1     = {1'b0, sy} + (SEG_W+1)'(1);
        sz1     = {1'b0, sz} + (SEG_W+1)'(1);
        nx_full = 16'(sz1) * 16'(sy1);
        ny_full = 16'(sx1) * 16'(sz1);
        nz_full = 16'(sx1) * 16'(sy1);
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_face_reg    <= req.face;
            a_col_reg     <= req.column;
            a_row_reg     <= req.row;
            a_gc_reg      <= gc;
            a_gr_reg      <= gr;
            a_eu_reg      <= eu;
            a_ev_reg      <= ev;
            a_en_reg      <= en;
            a_mu_reg      <= mu8[SEG_W-1:0];
            a_mv_reg      <= mv8[SEG_W-1:0];
            a_mu_neg_reg  <= mu_neg;
            a_mv_neg_reg  <= mv_neg;
            a_in_grid_reg <= in_grid;
            a_nx_reg      <= nx_full[NB_W-1:0];
            a_ny_reg      <= ny_full[NB_W-1:0];
            a_nz_reg      <= nz_full[NB_W-1:0];
        end
    end

    always_comb
    begin
        prod_u = DIVIDEND_W'(a_eu_reg) * DIVIDEND_W'(a_mu_reg);
        prod_v = DIVIDEND_W'(a_ev_reg) * DIVIDEND_W'(a_mv_reg);
        nx2    = {1'b0, a_nx_reg, 1'b0};
        case (a_face_reg)
            FACE_PX: base = '0;
            FACE_NX: base = IDX_W'(a_nx_reg);
            FACE_PY: base = nx2;
            FACE_NY: base = nx2 + IDX_W'(a_ny_reg);
            FACE_PZ: base = nx2 + {1'b0, a_ny_reg, 1'b0};
            default: base = nx2 + {1'b0, a_ny_reg, 1'b0} + IDX_W'(a_nz_reg);
        endcase
        gc1      = {1'b0, a_gc_reg} + (SEG_W+1)'(1);
        row_step = IDX_W'(gc1) * IDX_W'(a_row_reg);
        index    = base + IDX_W'(a_col_reg) + row_step;
        en_inc   = {1'b0, a_en_reg} + (EXT_W+1)'(1);

        side_next.in_grid    = a_in_grid_reg;
        side_next.face       = a_face_reg;
        side_next.u_neg      = a_mu_neg_reg;
        side_next.v_neg      = a_mv_neg_reg;
        side_next.off        = en_inc[EXT_W:1];
        side_next.normal_neg = a_face_reg[0] || (a_en_reg == '0);
        side_next.index      = index;
        side_next.quad       = (a_col_reg < a_gc_reg) && (a_row_reg < a_gr_reg);
        side_next.top        = (a_row_reg == '0);
        side_next.right      = (a_col_reg == a_gc_reg - SEG_W'(1));

        pos_u_next.dividend = prod_u + DIVIDEND_W'(a_gc_reg);
        pos_u_next.divisor  = {a_gc_reg, 1'b0};
        pos_v_next.dividend = prod_v + DIVIDEND_W'(a_gr_reg);
        pos_v_next.divisor  = {a_gr_reg, 1'b0};
        tex_u_next.dividend = {a_col_reg, 16'b0} + DIVIDEND_W'(a_gc_reg >> 1);
        tex_u_next.divisor  = {1'b0, a_gc_reg};
        tex_v_next.dividend = {a_row_reg, 16'b0} + DIVIDEND_W'(a_gr_reg >> 1);
        tex_v_next.divisor  = {1'b0, a_gr_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            side_reg  <= side_next;
            pos_u_reg <= pos_u_next;
            pos_v_reg <= pos_v_next;
            tex_u_reg <= tex_u_next;
            tex_v_reg <= tex_v_next;
        end
    end

    assign side     = side_reg;
    assign pos_u_op = pos_u_reg;
    assign pos_v_op = pos_v_reg;
    assign tex_u_op = tex_u_reg;
    assign tex_v_op = tex_v_reg;

endmodule

// ----- hdl/bmvg_finish.sv -----
// ----------------------------------------------------------------------------
// Vertex output stage
// Signs, saturates and places the coordinates, and registers the result.
// ----------------------------------------------------------------------------
module bmvg_finish (
    input  logic                       clk,
    input  logic                       en,
    input  bmvg_pkg::side_t            side,
    input  logic [bmvg_pkg::QUO_W-1:0] q_u,
    input  logic [bmvg_pkg::QUO_W-1:0] q_v,
    input  logic [bmvg_pkg::QUO_W-1:0] t_u,
    input  logic [bmvg_pkg::QUO_W-1:0] t_v,
    output bmvg_pkg::vtx_t             vtx
);
    import bmvg_pkg::*;

    logic [QUO_W-1:0] q_off;
    vtx_t             vtx_next, vtx_reg;

    always_comb
    begin
        q_off    = {1'b0, side.off};
        vtx_next = '0;
        case (side.face)
            FACE_PX:
            begin
                vtx_next.pos_x = sat_coord(q_off, 1'b0);
                vtx_next.pos_y = sat_coord(q_v, !side.v_neg);
                vtx_next.pos_z = sat_coord(q_u, !side.u_neg);
            end
            FACE_NX:
            begin
                vtx_next.pos_x = sat_coord(q_off, 1'b1);
                vtx_next.pos_y = sat_coord(q_v, !side.v_neg);
                vtx_next.pos_z = sat_coord(q_u, side.u_neg);
            end
            FACE_PY:
            begin
                vtx_next.pos_x = sat_coord(q_u, side.u_neg);
                vtx_next.pos_y = sat_coord(q_off, 1'b0);
                vtx_next.pos_z = sat_coord(q_v, side.v_neg);
            end
            FACE_NY:
            begin
                vtx_next.pos_x = sat_coord(q_u, side.u_neg);
                vtx_next.pos_y = sat_coord(q_off, 1'b1);
                vtx_next.pos_z = sat_coord(q_v, !side.v_neg);
            end
            FACE_PZ:
            begin
                vtx_next.pos_x = sat_coord(q_u, side.u_neg);
                vtx_next.pos_y = sat_coord(q_v, !side.v_neg);
                vtx_next.pos_z = sat_coord(q_off, 1'b0);
            end
            default:
            begin
                vtx_next.pos_x = sat_coord(q_u, !side.u_neg);
                vtx_next.pos_y = sat_coord(q_v, !side.v_neg);
                vtx_next.pos_z = sat_coord(q_off, 1'b1);
            end
        endcase
        vtx_next.in_grid         = 1'b1;
        vtx_next.normal_axis     = side.face[2:1];
        vtx_next.normal_negative = side.normal_neg;
        vtx_next.tex_u           = t_u;
        vtx_next.tex_v           = t_v;
        vtx_next.vertex_index    = side.index;
        vtx_next.quad_valid      = side.quad;
        vtx_next.top_edge_line   = side.quad && side.top;
        vtx_next.right_edge_line = side.quad && side.right;
        if (!side.in_grid)
            vtx_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vtx_reg <= vtx_next;
    end

    assign vtx = vtx_reg;

endmodule

// ----- hdl/box_mesh_vertex_generator_top.sv -----
// ----------------------------------------------------------------------------
// Box mesh vertex generator
// Vertex position, normal, texture coordinates, index and cell flags for a
// subdivided axis-aligned box, one request per cycle while req_stall is low.
//
//   Channel   Signals                                  Direction
//   req       req_valid, req_stall, req (req_t)        in
//   vtx       vtx_valid, vtx_stall, vtx (vtx_t)        out
//   config    psel, penable, pwrite, paddr, pwdata,    APB slave
//             prdata, pready
//
// One transaction per cycle sustained while vtx_stall is low; eight register
// stages: two setup stages, five divider stages (at most four quotient bits
// each) and the output stage, from which each vertex is offered.
// Reset clears every stage valid bit and loads the register defaults.
// A stalled output holds its transaction; earlier stages keep filling bubbles,
// and req_stall rises only once every stage holds a transaction.
// ----------------------------------------------------------------------------
module box_mesh_vertex_generator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bmvg_pkg::req_t                req,
    output logic                          vtx_valid,
    input  logic                          vtx_stall,
    output bmvg_pkg::vtx_t                vtx,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmvg_pkg::APB_AW-1:0]   paddr,
    input  logic [bmvg_pkg::APB_DW-1:0]   pwdata,
    output logic [bmvg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import bmvg_pkg::*;

    cfg_t                  cfg_reg, cfg_next;
    logic                  cfg_wr;
    logic [2:0]            reg_sel;
    logic [NUM_STAGES-1:0] en, v_reg, v_next;
    side_t                 side_b;
    side_t                 side_reg [DIV_STAGES];
    div_op_t               pos_u_op, pos_v_op, tex_u_op, tex_v_op;
    logic [QUO_W-1:0]      q_u, q_v, t_u, t_v;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = paddr[APB_AW-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                REG_BOX_WIDTH:  cfg_next.box_width  = pwdata[EXT_W-1:0];
                REG_BOX_HEIGHT: cfg_next.box_height = pwdata[EXT_W-1:0];
                REG_BOX_DEPTH:  cfg_next.box_depth  = pwdata[EXT_W-1:0];
                REG_SEGMENTS_X: cfg_next.segments_x = pwdata[SEG_W-1:0];
                REG_SEGMENTS_Y: cfg_next.segments_y = pwdata[SEG_W-1:0];
                REG_SEGMENTS_Z: cfg_next.segments_z = pwdata[SEG_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BOX_WIDTH:  prdata = APB_DW'(cfg_reg.box_width);
            REG_BOX_HEIGHT: prdata = APB_DW'(cfg_reg.box_height);
            REG_BOX_DEPTH:  prdata = APB_DW'(cfg_reg.box_depth);
            REG_SEGMENTS_X: prdata = APB_DW'(cfg_reg.segments_x);
            REG_SEGMENTS_Y: prdata = APB_DW'(cfg_reg.segments_y);
            REG_SEGMENTS_Z: prdata = APB_DW'(cfg_reg.segments_z);
            default:        prdata = '0;
        endcase
    end

    // advance a stage when it is empty or its successor advances
    assign en[ST_OUT] = !v_reg[ST_OUT] || !vtx_stall;
    for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign v_next[0] = en[0] ? req_valid : v_reg[0];
    for (genvar k = 1; k < NUM_STAGES; k++) begin : g_valid
        assign v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_width  <= EXT_RESET;
            cfg_reg.box_height <= EXT_RESET;
            cfg_reg.box_depth  <= EXT_RESET;
            cfg_reg.segments_x <= SEG_RESET;
            cfg_reg.segments_y <= SEG_RESET;
            cfg_reg.segments_z <= SEG_RESET;
            v_reg              <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            v_reg   <= v_next;
        end
    end

    assign req_stall = !en[ST_A];
    assign vtx_valid = v_reg[ST_OUT];

    bmvg_setup u_setup (
        .clk      (clk),
        .en_a     (en[ST_A]),
        .en_b     (en[ST_B]),
        .req      (req),
        .cfg      (cfg_reg),
        .side     (side_b),
        .pos_u_op (pos_u_op),
        .pos_v_op (pos_v_op),
        .tex_u_op (tex_u_op),
        .tex_v_op (tex_v_op)
    );

    bmvg_div u_div_pos_u (
        .clk      (clk),
        .en       (en[ST_DIV0 +: DIV_STAGES]),
        .op       (pos_u_op),
        .quotient (q_u)
    );

    bmvg_div u_div_pos_v (
        .clk      (clk),
        .en       (en[ST_DIV0 +: DIV_STAGES]),
        .op       (pos_v_op),
        .quotient (q_v)
    );

    bmvg_div u_div_tex_u (
        .clk      (clk),
        .en       (en[ST_DIV0 +: DIV_STAGES]),
        .op       (tex_u_op),
        .quotient (t_u)
    );

    bmvg_div u_div_tex_v (
        .clk      (clk),
        .en       (en[ST_DIV0 +: DIV_STAGES]),
        .op       (tex_v_op),
        .quotient (t_v)
    );

    // carry the side fields alongside the divider stages
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
        if (s == 0) begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[ST_DIV0 + s])
                    side_reg[s] <= side_b;
            end
        end
        else begin : g_next
            always_ff @(posedge clk)
            begin
                if (en[ST_DIV0 + s])
                    side_reg[s] <= side_reg[s-1];
            end
        end
    end

    bmvg_finish u_finish (
        .clk  (clk),
        .en   (en[ST_OUT]),
        .side (side_reg[DIV_STAGES-1]),
        .q_u  (q_u),
        .q_v  (q_v),
        .t_u  (t_u),
        .t_v  (t_v),
        .vtx  (vtx)
    );

endmodule
